// ===== sv/quaternion_to_tilt_heading_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef QUATERNION_TO_TILT_HEADING_MACROS_SVH
`define QUATERNION_TO_TILT_HEADING_MACROS_SVH

// Clocked assertion, quiet while reset is held.
`define QTH_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds through reset.
`define QTH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/qth_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package qth_pkg;

    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int ANGLE_FRAC_BITS_DEF   = 8;

    localparam int Z_FRAC = 16;      // fraction bits of the angle accumulator
    localparam int Z_W    = 28;      // angle accumulator width, degrees
    localparam int TW     = 34;      // width of the Q.30 terms
    localparam int CW     = 36;      // CORDIC x/y datapath width
    localparam int ABS_W  = 30;
    localparam int SQ_W   = 61;
    localparam int ROOT_W = 31;

    localparam logic signed [Z_W-1:0] DEG180_Z = Z_W'(180 << Z_FRAC);

    localparam logic [14:0] LOW_ALPHA_RST  = 15'd1280;
    localparam logic [14:0] HIGH_ALPHA_RST = 15'd21760;
    localparam logic [15:0] PENALTY_RST    = 16'd29491;
    localparam logic [15:0] QUALITY_ONE    = 16'd32768;

    typedef enum logic [1:0] {
        REG_LOW_ALPHA  = 2'd0,
        REG_HIGH_ALPHA = 2'd1,
        REG_PENALTY    = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic                   sat;
        logic [ABS_W-1:0]       abs_s;
        logic [SQ_W-1:0]        c2;
        logic signed [TW-1:0]   ys;
        logic signed [TW-1:0]   xs;
    } t_front;

    typedef struct packed {
        logic [14:0] alpha_deg;
        logic [14:0] beta_deg;
        logic [15:0] quality;
    } t_res;

    // atan(2^-i) in degrees, Z_FRAC fraction bits
    function automatic logic signed [Z_W-1:0] atan_tab(input logic [4:0] idx);
        logic signed [Z_W-1:0] v;
        unique case (idx)
            5'd0:  v = Z_W'(2949120);
            5'd1:  v = Z_W'(1740967);
            5'd2:  v = Z_W'(919879);
            5'd3:  v = Z_W'(466945);
            5'd4:  v = Z_W'(234379);
            5'd5:  v = Z_W'(117304);
            5'd6:  v = Z_W'(58666);
            5'd7:  v = Z_W'(29335);
            5'd8:  v = Z_W'(14668);
            5'd9:  v = Z_W'(7334);
            5'd10: v = Z_W'(3667);
            5'd11: v = Z_W'(1833);
            5'd12: v = Z_W'(917);
            5'd13: v = Z_W'(458);
            5'd14: v = Z_W'(229);
            5'd15: v = Z_W'(115);
            5'd16: v = Z_W'(57);
            5'd17: v = Z_W'(29);
            5'd18: v = Z_W'(14);
            5'd19: v = Z_W'(7);
            5'd20: v = Z_W'(4);
            5'd21: v = Z_W'(2);
            5'd22: v = Z_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== sv/qth_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface qth_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;

    modport source (output valid, output quat_w, output quat_x, output quat_y,
                    output quat_z, input ready);
    modport sink (input valid, input quat_w, input quat_x, input quat_y,
                  input quat_z, output ready);
endinterface

`default_nettype wire

// ===== sv/qth_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface qth_out_if;
    logic        valid;
    logic        ready;
    logic [14:0] alpha_deg;
    logic [14:0] beta_deg;
    logic [15:0] quality;

    modport source (output valid, output alpha_deg, output beta_deg,
                    output quality, input ready);
    modport sink (input valid, input alpha_deg, input beta_deg,
                  input quality, output ready);
endinterface

`default_nettype wire

// ===== sv/qth_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module qth_front import qth_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [15:0] i_quat_w,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    output logic               o_valid,
    output t_front             o_data
);

    logic r_v1, r_v2, r_v3;
    logic signed [31:0] r_wy, r_zx, r_wz, r_xy, r_yy, r_zz;
    logic               r2_sat;
    logic [ABS_W-1:0]   r2_abs;
    logic signed [TW-1:0] r2_ys, r2_xs;
    t_front             r3;

    logic signed [TW-1:0] n_diff, n_s, n_abs, n_sum, n_sq, n_ys, n_xs;

    always_comb begin
        n_diff = $signed({{2{r_wy[31]}}, r_wy}) - $signed({{2{r_zx[31]}}, r_zx});
        n_s    = n_diff <<< 1;
        n_abs  = n_s[TW-1] ? -n_s : n_s;
        n_sum  = $signed({{2{r_wz[31]}}, r_wz}) + $signed({{2{r_xy[31]}}, r_xy});
        n_ys   = n_sum <<< 1;
        n_sq   = $signed({{2{r_yy[31]}}, r_yy}) + $signed({{2{r_zz[31]}}, r_zz});
        n_xs   = $signed(TW'(1) <<< 30) - (n_sq <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wy <= i_quat_w * i_quat_y;
            r_zx <= i_quat_z * i_quat_x;
            r_wz <= i_quat_w * i_quat_z;
            r_xy <= i_quat_x * i_quat_y;
            r_yy <= i_quat_y * i_quat_y;
            r_zz <= i_quat_z * i_quat_z;

            r2_sat <= (n_abs[TW-1:30] != '0);
            r2_abs <= n_abs[ABS_W-1:0];
            r2_ys  <= n_ys;
            r2_xs  <= n_xs;

            r3.sat   <= r2_sat;
            r3.abs_s <= r2_abs;
            r3.c2    <= (SQ_W'(1) << 60) - SQ_W'(60'(r2_abs) * 60'(r2_abs));
            r3.ys    <= r2_ys;
            r3.xs    <= r2_xs;
        end
    end

    assign o_valid = r_v3;
    assign o_data  = r3;

endmodule

`default_nettype wire

// ===== sv/qth_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none

module qth_isqrt import qth_pkg::*; #(
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [SQ_W-1:0]   i_v,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output logic [SIDE_W-1:0] o_side
);

    // one result bit per stage, from 4^30 down to 4^0
    localparam int NS = 31;

    logic [SQ_W-1:0]   r_rem  [NS];
    logic [SQ_W:0]     r_root [NS];
    logic [SIDE_W-1:0] r_side [NS];
    logic              r_vld  [NS];

    logic [SQ_W-1:0]   n_rem  [NS];
    logic [SQ_W:0]     n_root [NS];

    always_comb begin
        logic [SQ_W-1:0] p_rem;
        logic [SQ_W:0]   p_root;
        logic [SQ_W:0]   bitv;
        logic [SQ_W:0]   sum;
        for (int k = 0; k < NS; k++) begin
            p_rem  = (k == 0) ? i_v : r_rem[(k == 0) ? 0 : k - 1];
            p_root = (k == 0) ? '0 : r_root[(k == 0) ? 0 : k - 1];
            bitv   = (SQ_W + 1)'(1) << (60 - 2 * k);
            sum    = p_root + bitv;
            if ({1'b0, p_rem} >= sum) begin
                n_rem[k]  = p_rem - sum[SQ_W-1:0];
                n_root[k] = (p_root >> 1) + bitv;
            end else begin
                n_rem[k]  = p_rem;
                n_root[k] = p_root >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < NS; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 1; k < NS; k++) r_side[k] <= r_side[k-1];
            for (int k = 0; k < NS; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
            end
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_root  = r_root[NS-1][ROOT_W-1:0];
    assign o_side  = r_side[NS-1];

endmodule

`default_nettype wire

// ===== sv/qth_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none

module qth_cordic import qth_pkg::*; #(
    parameter int ITER   = CORDIC_ITERATIONS_DEF,
    parameter int SIDE_W = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [TW-1:0] i_y,
    input  logic signed [TW-1:0] i_x,
    input  logic [SIDE_W-1:0]    i_side,
    output logic                 o_valid,
    output logic signed [Z_W-1:0] o_z,
    output logic [SIDE_W-1:0]    o_side
);

    // stage 0 folds the vector into the right half plane, then one stage per step
    localparam int NS = ITER + 1;

    logic signed [CW-1:0]  r_x  [NS];
    logic signed [CW-1:0]  r_y  [NS];
    logic signed [Z_W-1:0] r_z  [NS];
    logic                  r_zf [NS];
    logic                  r_vld[NS];
    logic [SIDE_W-1:0]     r_side[NS];

    logic signed [CW-1:0]  n_x  [NS];
    logic signed [CW-1:0]  n_y  [NS];
    logic signed [Z_W-1:0] n_z  [NS];
    logic                  n_zf;

    always_comb begin
        logic signed [CW-1:0] xin, yin, xs, ys;
        xin  = CW'(i_x);
        yin  = CW'(i_y);
        n_zf = (yin == '0);
        if (n_zf) begin
            n_x[0] = xin;
            n_y[0] = yin;
            n_z[0] = xin[CW-1] ? DEG180_Z : '0;
        end else if (xin[CW-1]) begin
            n_x[0] = -xin;
            n_y[0] = -yin;
            n_z[0] = yin[CW-1] ? -DEG180_Z : DEG180_Z;
        end else begin
            n_x[0] = xin;
            n_y[0] = yin;
            n_z[0] = '0;
        end
        for (int k = 1; k < NS; k++) begin
            xs = r_x[k-1] >>> (k - 1);
            ys = r_y[k-1] >>> (k - 1);
            if (r_y[k-1][CW-1]) begin
                n_x[k] = r_x[k-1] - ys;
                n_y[k] = r_y[k-1] + xs;
                n_z[k] = r_z[k-1] - atan_tab(5'(k - 1));
            end else begin
                n_x[k] = r_x[k-1] + ys;
                n_y[k] = r_y[k-1] - xs;
                n_z[k] = r_z[k-1] + atan_tab(5'(k - 1));
            end
            // hold the angle of a vector that entered with zero y
            if (r_zf[k-1]) n_z[k] = r_z[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < NS; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zf[0]   <= n_zf;
            r_side[0] <= i_side;
            for (int k = 1; k < NS; k++) begin
                r_zf[k]   <= r_zf[k-1];
                r_side[k] <= r_side[k-1];
            end
            for (int k = 0; k < NS; k++) begin
                r_x[k] <= n_x[k];
                r_y[k] <= n_y[k];
                r_z[k] <= n_z[k];
            end
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_z     = r_z[NS-1];
    assign o_side  = r_side[NS-1];

endmodule

`default_nettype wire

// ===== sv/quaternion_to_tilt_heading.sv =====
`timescale 1ns / 1ps
`default_nettype none

//  channel | direction | handshake       | word
//  i_in    | in        | valid / ready   | quat_w, quat_x, quat_y, quat_z (s16 Q1.15)
//  o_out   | out       | valid / ready   | alpha_deg u15, beta_deg u15, quality u16
//  apb     | in / out  | psel, penable   | three limit / penalty registers at 0, 4, 8
//
//  One word per cycle while the skid slot is empty; the path to the output register holds
//  three product stages, 31 square root stages, the CORDIC steps plus a fold stage, one
//  rounding stage and the output register itself.
//  Reset (synchronous, active low) clears only the valid bits and the configuration registers.
//  A stall holds the whole pipeline once the skid slot behind the output register fills;
//  until then a new word is taken while the result waits.

module quaternion_to_tilt_heading import qth_pkg::*; #(
    parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF,
    parameter int ANGLE_FRAC_BITS   = ANGLE_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qth_in_if.sink      i_in,
    qth_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SIDE_W = 1 + ABS_W + 2 * TW;
    localparam int SH_A   = Z_FRAC - ANGLE_FRAC_BITS;
    localparam int SH_B   = Z_FRAC - (ANGLE_FRAC_BITS - 2);
    localparam logic signed [29:0] HALF_A = (SH_A > 0) ? 30'(1 << (SH_A - 1)) : '0;
    localparam logic signed [29:0] HALF_B = (SH_B > 0) ? 30'(1 << (SH_B - 1)) : '0;
    localparam logic signed [29:0] ALPHA_MAX = 30'(90 << ANGLE_FRAC_BITS);
    localparam logic signed [29:0] CIRCLE    = 30'(360 << (ANGLE_FRAC_BITS - 2));

    // ---------------- configuration registers ----------------
    logic [14:0] r_low, r_high;
    logic [15:0] r_pen;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= LOW_ALPHA_RST;
            r_high <= HIGH_ALPHA_RST;
            r_pen  <= PENALTY_RST;
        end else if (cfg_wr) begin
            unique case (t_reg_idx'(paddr[3:2]))
                REG_LOW_ALPHA:  r_low  <= pwdata[14:0];
                REG_HIGH_ALPHA: r_high <= pwdata[14:0];
                REG_PENALTY:    r_pen  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_LOW_ALPHA:  prdata = {17'd0, r_low};
            REG_HIGH_ALPHA: prdata = {17'd0, r_high};
            REG_PENALTY:    prdata = {16'd0, r_pen};
            default:        prdata = '0;
        endcase
    end

    // ---------------- pipeline ----------------
    // the whole pipeline advances while the skid slot is empty
    logic   en;
    logic   r_skid_v, r_out_v, r_fv;
    t_res   r_skid, r_out, r_f;

    assign en         = !r_skid_v;
    assign i_in.ready = en;

    logic   front_v;
    t_front front_d;

    qth_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_in.valid),
        .i_quat_w (i_in.quat_w),
        .i_quat_x (i_in.quat_x),
        .i_quat_y (i_in.quat_y),
        .i_quat_z (i_in.quat_z),
        .o_valid  (front_v),
        .o_data   (front_d)
    );

    logic              sq_v;
    logic [ROOT_W-1:0] sq_root;
    logic [SIDE_W-1:0] sq_side;
    logic              sq_sat;
    logic [ABS_W-1:0]  sq_abs;
    logic signed [TW-1:0] sq_ys, sq_xs;

    qth_isqrt #(.SIDE_W(SIDE_W)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front_v),
        .i_v     (front_d.c2),
        .i_side  ({front_d.sat, front_d.abs_s, front_d.ys, front_d.xs}),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    assign {sq_sat, sq_abs, sq_ys, sq_xs} = sq_side;

    // pitch: atan2(|s|, sqrt(1 - s^2)); yaw: atan2 of the heading terms
    logic signed [Z_W-1:0] z_pitch, z_yaw;
    logic                  p_sat, y_v;

    qth_cordic #(.ITER(CORDIC_ITERATIONS), .SIDE_W(1)) u_cordic_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_v),
        .i_y     ($signed({{(TW - ABS_W){1'b0}}, sq_abs})),
        .i_x     ($signed({{(TW - ROOT_W){1'b0}}, sq_root})),
        .i_side  (sq_sat),
        .o_valid (),
        .o_z     (z_pitch),
        .o_side  (p_sat)
    );

    qth_cordic #(.ITER(CORDIC_ITERATIONS), .SIDE_W(1)) u_cordic_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_v),
        .i_y     (sq_ys),
        .i_x     (sq_xs),
        .i_side  (1'b0),
        .o_valid (y_v),
        .o_z     (z_yaw),
        .o_side  ()
    );

    // ---------------- rounding, wrap and score ----------------
    logic signed [29:0] n_alpha, n_beta;
    t_res               n_res;

    always_comb begin
        n_alpha = ($signed({{(30 - Z_W){z_pitch[Z_W-1]}}, z_pitch}) + HALF_A) >>> SH_A;
        if (n_alpha < 0)         n_alpha = '0;
        if (n_alpha > ALPHA_MAX) n_alpha = ALPHA_MAX;
        // a pitch term at or past one pins alpha to the right angle
        if (p_sat)               n_alpha = ALPHA_MAX;

        n_beta = ($signed({{(30 - Z_W){z_yaw[Z_W-1]}}, z_yaw}) + HALF_B) >>> SH_B;
        if (n_beta < 0)            n_beta = n_beta + CIRCLE;
        else if (n_beta >= CIRCLE) n_beta = n_beta - CIRCLE;

        n_res.alpha_deg = n_alpha[14:0];
        n_res.beta_deg  = n_beta[14:0];
        if (n_alpha < $signed({15'd0, r_low}) || n_alpha > $signed({15'd0, r_high}))
            n_res.quality = (r_pen > QUALITY_ONE) ? QUALITY_ONE : r_pen;
        else
            n_res.quality = QUALITY_ONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_fv <= 1'b0;
        else if (en)  r_fv <= y_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) r_f <= n_res;
    end

    // ---------------- output register and skid slot ----------------
    logic take, pop;
    assign take = en && r_fv;
    assign pop  = r_out_v && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            // drain the skid slot first
            if (pop) begin
                r_out    <= r_skid;
                r_skid_v <= 1'b0;
            end
        end else if (take) begin
            if (!r_out_v || pop) begin
                r_out   <= r_f;
                r_out_v <= 1'b1;
            end else begin
                r_skid   <= r_f;
                r_skid_v <= 1'b1;
            end
        end else if (pop) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_out.valid     = r_out_v;
    assign o_out.alpha_deg = r_out.alpha_deg;
    assign o_out.beta_deg  = r_out.beta_deg;
    assign o_out.quality   = r_out.quality;

endmodule

`default_nettype wire

// ===== sv/qth_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "quaternion_to_tilt_heading_macros.svh"

module qth_checker #(
    parameter int ANGLE_FRAC_BITS = 8
) (
    input logic       i_clk,
    input logic       i_rst_n,
    qth_in_if.sink    i_in,
    qth_out_if.source o_out,
    input logic       pready
);

    localparam int ALPHA_MAX = 90 << ANGLE_FRAC_BITS;
    localparam int CIRCLE    = 360 << (ANGLE_FRAC_BITS - 2);
    localparam bit IN_RANGE  = (ANGLE_FRAC_BITS <= 8);

    // hold a stalled result word
    `QTH_ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.alpha_deg) && $stable(o_out.beta_deg) && $stable(o_out.quality), "result word dropped or changed while stalled")

    `QTH_ASSERT_CLK(a_angle_range, i_clk, i_rst_n, o_out.valid && IN_RANGE |-> 32'(o_out.alpha_deg) <= ALPHA_MAX && 32'(o_out.beta_deg) < CIRCLE, "angle out of range")

    `QTH_ASSERT_CLK(a_quality_range, i_clk, i_rst_n, o_out.valid |-> o_out.quality <= 16'd32768, "quality above one")

    // after a reset edge: empty output and ready for input
    `QTH_ASSERT_ALWAYS(a_reset_state, i_clk, !i_rst_n |=> !o_out.valid && i_in.ready, "pipeline not empty after reset")

    `QTH_ASSERT_ALWAYS(a_pready, i_clk, pready, "config port not ready")

endmodule

bind quaternion_to_tilt_heading qth_checker #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_qth_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_in    (i_in),
    .o_out   (o_out),
    .pready  (pready)
);

`default_nettype wire

// ===== tb/tb_quaternion_to_tilt_heading.sv =====
`timescale 1ns / 1ps

module tb_quaternion_to_tilt_heading;
    import qth_pkg::*;

    localparam int FRAC_BITS  = ANGLE_FRAC_BITS_DEF;
    localparam int STEPS      = CORDIC_ITERATIONS_DEF;
    localparam int PIPE_DEPTH = 37 + STEPS;        // depth of the pipeline to the output register
    localparam int SETTLE     = PIPE_DEPTH + 12;   // margin before a register write or the end
    localparam int CYCLE_CAP  = 400000;

    // atan(2^-i) in degrees with 16 fraction bits
    localparam longint ARCTAN_DEG [16] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    typedef struct {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } quat_word_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    qth_in_if  in_ch ();
    qth_out_if out_ch ();

    quaternion_to_tilt_heading DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 i_clk = ~i_clk;

    // predictor copy of the registers
    logic [14:0] low_limit  = LOW_ALPHA_RST;
    logic [14:0] high_limit = HIGH_ALPHA_RST;
    logic [15:0] penalty    = PENALTY_RST;

    quat_word_t pending_words [$];
    t_res       expected_angles [$];

    bit     calm_tail = 1'b0;   // no idling on either side once set
    bit     in_taken = 1'b0;
    int     send_gap = 0;
    int     stall_len = 0;
    int     mismatches = 0;
    int     words_checked = 0;
    int     penalized_seen = 0;
    longint cycles = 0;

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    // vectoring atan2 in degrees, 16 fraction bits, range (-180, 180]
    function automatic longint cordic_angle(longint yv, longint xv);
        longint ang;
        longint xsh;
        longint ysh;
        ang = 0;
        if (yv == 0) return (xv < 0) ? (longint'(180) << 16) : 0;
        if (xv < 0) begin
            ang = (yv >= 0) ? (longint'(180) << 16) : -(longint'(180) << 16);
            xv = -xv;
            yv = -yv;
        end
        for (int i = 0; i < STEPS; i++) begin
            xsh = xv >>> i;
            ysh = yv >>> i;
            if (yv < 0) begin
                xv = xv - ysh;
                yv = yv + xsh;
                ang = ang - ARCTAN_DEG[i];
            end else begin
                xv = xv + ysh;
                yv = yv - xsh;
                ang = ang + ARCTAN_DEG[i];
            end
        end
        return ang;
    endfunction

    function automatic longint round_units(longint ang, int frac);
        int sh;
        sh = 16 - frac;
        return (ang + ((sh > 0) ? (longint'(1) << (sh - 1)) : 0)) >>> sh;
    endfunction

    function automatic t_res predict_orientation(quat_word_t q);
        t_res   r;
        longint w, x, y, z;
        longint pitch_term, pitch_abs, alpha, beta, head_y, head_x;
        longint alpha_max, circle;
        longint unsigned cos_sq;
        w = q.w;
        x = q.x;
        y = q.y;
        z = q.z;
        alpha_max = longint'(90) << FRAC_BITS;
        circle = longint'(360) << (FRAC_BITS - 2);
        pitch_term = 2 * (w * y - z * x);
        pitch_abs = (pitch_term < 0) ? -pitch_term : pitch_term;
        if (pitch_abs >= (longint'(1) << 30)) begin
            alpha = alpha_max;   // gimbal lock: pin to 90 degrees
        end else begin
            cos_sq = (64'd1 << 60) - longint'(pitch_abs) * longint'(pitch_abs);
            alpha = round_units(cordic_angle(pitch_abs, int_sqrt(cos_sq)), FRAC_BITS);
            if (alpha < 0) alpha = 0;
            if (alpha > alpha_max) alpha = alpha_max;
        end
        head_y = 2 * (w * z + x * y);
        head_x = (longint'(1) << 30) - 2 * (y * y + z * z);
        beta = round_units(cordic_angle(head_y, head_x), FRAC_BITS - 2);
        while (beta < 0) beta = beta + circle;
        while (beta >= circle) beta = beta - circle;
        r.alpha_deg = alpha[14:0];
        r.beta_deg = beta[14:0];
        r.quality = QUALITY_ONE;
        if (alpha < longint'(low_limit) || alpha > longint'(high_limit))
            r.quality = (penalty > QUALITY_ONE) ? QUALITY_ONE : penalty;
        return r;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("[%0t] %s mismatch on word %0d: got %0d, want %0d",
                 $time, field, words_checked, got, want);
        mismatches++;
    endtask

    // Driver: change inputs at the falling edge, advance only after a handshake.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            out_ch.ready <= 1'b0;
        end else begin
            if (stall_len > 0) begin
                stall_len <= stall_len - 1;
                out_ch.ready <= 1'b0;
            end else if (!calm_tail && $urandom_range(0, 9) == 0) begin
                stall_len <= $urandom_range(0, 12);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end

            if (!in_ch.valid || in_taken) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    in_ch.valid <= 1'b0;
                end else if (!calm_tail && $urandom_range(0, 9) == 0) begin
                    send_gap <= $urandom_range(0, 12);
                    in_ch.valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    quat_word_t q;
                    q = pending_words.pop_front();
                    in_ch.quat_w <= q.w;
                    in_ch.quat_x <= q.x;
                    in_ch.quat_y <= q.y;
                    in_ch.quat_z <= q.z;
                    in_ch.valid <= 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: predict on every accepted input word, check every accepted result word.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycles, expected_angles.size());
            $display("quaternion_to_tilt_heading regression: fail");
            $finish;
        end else begin
            in_taken <= i_rst_n && in_ch.valid && in_ch.ready;
            if (i_rst_n && in_ch.valid && in_ch.ready) begin
                quat_word_t q;
                q.w = in_ch.quat_w;
                q.x = in_ch.quat_x;
                q.y = in_ch.quat_y;
                q.z = in_ch.quat_z;
                expected_angles.push_back(predict_orientation(q));
            end
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                if (expected_angles.size() == 0) begin
                    report_mismatch("unexpected word", 1, 0);
                end else begin
                    t_res want;
                    want = expected_angles.pop_front();
                    if (out_ch.alpha_deg !== want.alpha_deg)
                        report_mismatch("alpha_deg", out_ch.alpha_deg, want.alpha_deg);
                    if (out_ch.beta_deg !== want.beta_deg)
                        report_mismatch("beta_deg", out_ch.beta_deg, want.beta_deg);
                    if (out_ch.quality !== want.quality)
                        report_mismatch("quality", out_ch.quality, want.quality);
                    if (want.quality != QUALITY_ONE) penalized_seen++;
                end
                words_checked++;
            end
        end
    end

    task automatic push_quat(int w, int x, int y, int z);
        quat_word_t q;
        q.w = 16'(w);
        q.x = 16'(x);
        q.y = 16'(y);
        q.z = 16'(z);
        pending_words.push_back(q);
    endtask

    // mostly unit quaternions, some near gimbal lock, some raw noise
    task automatic push_random_quat();
        real a, b, c, d, n;
        int  pick;
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
            push_quat($urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 65535));
        end else if (pick == 2) begin
            a = 23170 + $urandom_range(0, 40) - 20;
            push_quat(int'(a), $urandom_range(0, 60) - 30,
                      ($urandom_range(0, 1) ? 1 : -1) * int'(a), $urandom_range(0, 60) - 30);
        end else begin
            a = real'($urandom_range(0, 65535)) - 32768.0;
            b = real'($urandom_range(0, 65535)) - 32768.0;
            c = real'($urandom_range(0, 65535)) - 32768.0;
            d = real'($urandom_range(0, 65535)) - 32768.0;
            n = $sqrt(a * a + b * b + c * c + d * d);
            if (n < 1.0) begin
                a = 1.0;
                n = 1.0;
            end
            push_quat($rtoi(a * 32767.0 / n), $rtoi(b * 32767.0 / n),
                      $rtoi(c * 32767.0 / n), $rtoi(d * 32767.0 / n));
        end
    endtask

    // APB setup, then access; the write lands at the rising edge in the access phase.
    task automatic apb_write(t_reg_idx idx, logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_LOW_ALPHA:  low_limit = value[14:0];
            REG_HIGH_ALPHA: high_limit = value[14:0];
            REG_PENALTY:    penalty = value[15:0];
            default: ;
        endcase
    endtask

    // Drain the pipeline: every expected word back, then wait out SETTLE on top.
    task automatic drain();
        while (pending_words.size() > 0 || in_ch.valid || expected_angles.size() > 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic set_band(int lo, int hi, int pen);
        apb_write(REG_LOW_ALPHA, 32'(lo));
        apb_write(REG_HIGH_ALPHA, 32'(hi));
        apb_write(REG_PENALTY, 32'(pen));
    endtask

    task automatic random_phase(int count);
        repeat (count) push_random_quat();
        drain();
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.quat_w = '0;
        in_ch.quat_x = '0;
        in_ch.quat_y = '0;
        in_ch.quat_z = '0;
        out_ch.ready = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed words under reset settings
        push_quat(0, 0, 0, 0);                       // null quaternion
        push_quat(32767, 0, 0, 0);                   // identity
        push_quat(-32768, 0, 0, 0);
        push_quat(32767, 32767, 32767, 32767);       // non-unit, extremes
        push_quat(-32768, -32768, -32768, -32768);
        push_quat(-32768, 32767, -32768, 32767);
        push_quat(23170, 0, 23170, 0);               // pitch term just under one
        push_quat(23170, 0, -23170, 0);
        push_quat(23171, 0, 23171, 0);               // just beyond one
        push_quat(23169, 0, 23169, 0);               // just below one
        push_quat(0, 0, 0, 32767);                   // heading on the negative x axis
        push_quat(0, 0, 0, -32768);
        push_quat(5, -5, 16384, 16384);              // heading vector is zero
        push_quat(32767, 0, 0, -1);                  // heading rounds up to 360
        push_quat(32767, 0, 0, 1);
        push_quat(23170, 0, 0, 23170);               // 90 degree heading
        push_quat(23170, 0, 0, -23170);
        push_quat(32767, 0, 1400, 0);                // alpha near the low limit
        push_quat(23170, 23170, 0, 0);               // pure roll
        push_quat(16384, 16384, 16384, 16384);
        drain();

        random_phase(120);

        set_band(0, 23040, 32768);                   // widest band, no penalty effect
        random_phase(90);

        set_band(23040, 0, 0);                       // everything penalized to zero
        push_quat(23170, 0, 23170, 0);
        push_quat(32767, 0, 0, 0);
        random_phase(90);

        set_band(32767, 32767, 65535);               // penalty saturates at 1.0
        random_phase(60);

        set_band($urandom_range(0, 11520), $urandom_range(11520, 23040),
                 $urandom_range(0, 32768));
        random_phase(120);

        // last part without idling on either side
        set_band(11520, 11520, 1);
        calm_tail = 1'b1;
        random_phase(170);

        $display("checked %0d result words over six register settings, %0d penalized",
                 words_checked, penalized_seen);
        $display("directed gimbal lock, null heading and wrap cases plus random orientations");
        if (mismatches == 0) begin
            $display("quaternion_to_tilt_heading regression: pass");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("quaternion_to_tilt_heading regression: fail");
        end
        $finish;
    end

endmodule
